// ----- design/bal_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and codes of the bounded array list: word formats of the
// request and result channels, opcodes, status codes and sizing constants.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int DEF_STORE_DEPTH = 32;
  localparam int RESULT_LIMIT    = 32;
  localparam int CAP_W           = 6;
  localparam int COUNT_OUT_W     = 6;
  localparam int DATA_W          = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     element_valid;
    logic signed [DATA_W-1:0] element_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     last_result;
  } out_word_t;

endpackage
`default_nettype wire

// ----- design/bal_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bal_store
// Entry memory of the list: one write port and one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module bal_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- design/bounded_array_list_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list_top
// Packed list of signed 32-bit words held in one synchronous memory.
// ----------------------------------------------------------------------------
// The block takes one request word at a time. An append, a full list or an
// unknown opcode goes through the response state, and the result word is
// registered from there. A remove scans one entry per cycle from the head
// until it finds a match and then moves every later entry down one place, one
// per cycle; a dump emits one entry per cycle while the result side takes
// every word at once. These rates are set by the single read port of the
// entry memory. Stored entries are never cleared; only the entry count, the
// capacity, the state and the output valid are reset.
module bounded_array_list_top
  import bal_pkg::*;
#(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_word,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DUMP  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [DATA_W-1:0] val_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic          in_fire;
  logic          slot_free;
  logic          room;
  logic [CW-1:0] ptr_p1;
  logic [CW-1:0] ptr_p2;
  logic [CW-1:0] count_w;
  logic          dump_last;

  bal_store #(
    .DEPTH(STORE_DEPTH),
    .AW   (AW),
    .DW   (DATA_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign count_w   = CW'(count_r);
  assign ptr_p1    = CW'(ptr_r) + CW'(1);
  assign ptr_p2    = CW'(ptr_r) + CW'(2);
  assign room      = (count_w < CW'(cap_r)) && (count_w < CW'(STORE_DEPTH));
  assign dump_last = (ptr_p1 == count_w) || (ptr_p1 == CW'(RESULT_LIMIT));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[AW-1:0];
    wr_data       = in_word.operand_value;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ptr_nxt = '0;
          st_nxt  = ST_OK;
          case (in_word.opcode)
            OP_APPEND: begin
              state_nxt = S_RESP;
              if (room) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end else begin
                st_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SRCH;
              end
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (rd_data == val_r) begin
          if (ptr_p1 == count_w) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ptr_p1[AW-1:0];
            state_nxt = S_SHIFT;
          end
        end else if (ptr_p1 == count_w) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_p1[AW-1:0];
          ptr_nxt = ptr_p1[AW-1:0];
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if (ptr_p2 == count_w) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_p2[AW-1:0];
          ptr_nxt = ptr_p1[AW-1:0];
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.status        = ST_OK;
          out_word_nxt.element_valid = 1'b1;
          out_word_nxt.element_value = rd_data;
          out_word_nxt.entry_count   = COUNT_OUT_W'(count_r);
          out_word_nxt.last_result   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_p1[AW-1:0];
            ptr_nxt = ptr_p1[AW-1:0];
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.status        = st_r;
          out_word_nxt.element_valid = 1'b0;
          out_word_nxt.element_value = '0;
          out_word_nxt.entry_count   = COUNT_OUT_W'(count_r);
          out_word_nxt.last_result   = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    st_r       <= st_nxt;
    out_word_r <= out_word_nxt;
    if (in_fire) begin
      val_r <= in_word.operand_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("request accepted while a previous word was still in work");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_word.opcode == OP_APPEND) && room)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append with room did not grow the list");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (ptr_p2 <= count_w))
    else $error("shift pointer ran past the stored entries");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_w <= CW'(STORE_DEPTH)))
    else $error("entry count exceeds the store depth");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DUMP) && slot_free && dump_last) |=> in_ready && out_valid)
    else $error("final dump word did not return the block to idle");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded array list. A driver feeds request
// words from a queue with random gaps, and the result side stalls at random.
// Every accepted request is run through a behavioral copy of the list. The
// expected result words are queued and compared in order with each result
// word the block delivers. The run steps through several capacity settings:
// full size, above the store depth, zero, one, and lowered below the count.
// ----------------------------------------------------------------------------
module tb_top;
  import bal_pkg::*;

  localparam int DEPTH = DEF_STORE_DEPTH;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = DEPTH + 8;

  typedef logic signed [DATA_W-1:0] data_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready;
  out_word_t out_word;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  in_word_t request_queue[$];
  out_word_t pending_results[$];
  out_word_t due_word;

  data_t list_mem[DEPTH];
  int list_len;
  logic [CAP_W-1:0] list_cap;
  data_t value_pool[8];

  int queued_count;
  int accepted_count;
  int error_count;
  int cycle_count;
  int in_gap;
  int out_stall;
  bit in_burst;
  bit out_burst;
  logic in_taken;

  bounded_array_list_top #(
    .STORE_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic out_word_t make_result(logic [1:0] status, logic elem_valid,
                                            data_t value, logic last);
    out_word_t r;
    r.status = status;
    r.element_valid = elem_valid;
    r.element_value = value;
    r.entry_count = COUNT_OUT_W'(list_len);
    r.last_result = last;
    return r;
  endfunction

  task automatic apply_list_op(in_word_t w);
    int cap;
    int hit;
    cap = (list_cap > DEPTH) ? DEPTH : int'(list_cap);
    hit = -1;
    case (w.opcode)
      OP_APPEND: begin
        if (list_len < cap) begin
          list_mem[list_len] = w.operand_value;
          list_len++;
          pending_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
        end else begin
          pending_results.push_back(make_result(ST_FULL, 1'b0, '0, 1'b1));
        end
      end
      OP_REMOVE: begin
        if (list_len == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_mem[i] == w.operand_value) hit = i;
          if (hit < 0) begin
            pending_results.push_back(make_result(ST_NOT_FOUND, 1'b0, '0, 1'b1));
          end else begin
            for (int i = hit; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
            pending_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
          end
        end
      end
      OP_DUMP: begin
        if (list_len == 0) begin
          pending_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++)
            pending_results.push_back(make_result(ST_OK, 1'b1, list_mem[i],
                                                  i == list_len - 1));
        end
      end
      default: begin
        pending_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1));
      end
    endcase
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic data_t rand_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return data_t'($urandom);
  endfunction

  task automatic add_request(logic [1:0] op, data_t value);
    in_word_t w;
    w.opcode = op;
    w.operand_value = value;
    request_queue.push_back(w);
    queued_count++;
  endtask

  task automatic add_random(int n);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      op = (r < 45) ? OP_APPEND : (r < 80) ? OP_REMOVE : (r < 95) ? OP_DUMP : OP_NOP;
      add_request(op, rand_value());
    end
  endtask

  task automatic add_appends(int n);
    for (int i = 0; i < n; i++) add_request(OP_APPEND, rand_value());
  endtask

  task automatic add_drain();
    for (int i = 0; i < list_len; i++) add_request(OP_REMOVE, list_mem[i]);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    list_cap = cap;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (request_queue.size() != 0) begin
        in_word <= request_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
        in_gap = pick_gap(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 24) == 0) out_burst = !out_burst;
      out_stall = pick_gap(out_burst);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bounded_array_list_top test failed");
      $finish;
    end else begin
      in_taken <= rst_n && in_valid && in_ready;
      if (rst_n && in_valid && in_ready) begin
        apply_list_op(in_word);
        accepted_count++;
      end
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got %p", $time, out_word);
          error_count++;
        end else begin
          due_word = pending_results.pop_front();
          if (out_word !== due_word) begin
            $display("%0t: result mismatch: expected status=%0d valid=%0b value=%0d ",
                     $time, due_word.status, due_word.element_valid,
                     due_word.element_value,
                     "count=%0d last=%0b, got status=%0d valid=%0b value=%0d ",
                     due_word.entry_count, due_word.last_result, out_word.status,
                     out_word.element_valid, out_word.element_value,
                     "count=%0d last=%0b",
                     out_word.entry_count, out_word.last_result);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_taken = 1'b0;
    list_len = 0;
    list_cap = CAP_RESET;
    value_pool[0] = {1'b1, {(DATA_W - 1){1'b0}}};
    value_pool[1] = {1'b0, {(DATA_W - 1){1'b1}}};
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int i = 4; i < 8; i++) value_pool[i] = data_t'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_capacity(CAP_RESET);
    add_request(OP_DUMP, '0);
    add_request(OP_REMOVE, 32'sd5);
    add_request(OP_NOP, 32'sd7);
    add_request(OP_APPEND, value_pool[0]);
    add_request(OP_APPEND, value_pool[1]);
    add_request(OP_APPEND, value_pool[2]);
    add_request(OP_APPEND, value_pool[3]);
    add_request(OP_APPEND, value_pool[1]);
    add_request(OP_DUMP, '0);
    add_request(OP_REMOVE, 32'sd123);
    add_request(OP_REMOVE, value_pool[1]);
    add_request(OP_REMOVE, value_pool[0]);
    add_request(OP_REMOVE, value_pool[1]);
    add_request(OP_DUMP, '0);
    add_request(OP_REMOVE, value_pool[3]);
    add_request(OP_REMOVE, value_pool[2]);
    add_request(OP_APPEND, 32'sh55555555);
    add_request(OP_APPEND, 32'shAAAAAAAA);
    add_request(OP_NOP, '1);
    add_request(OP_DUMP, '0);

    add_appends(34);
    add_request(OP_DUMP, '0);
    add_random(20);

    set_capacity(6'd3);
    add_random(20);
    wait_idle();
    add_drain();

    set_capacity(6'd1);
    add_random(15);

    set_capacity(6'd0);
    add_random(12);

    set_capacity(6'd63);
    add_appends(10);
    add_random(10);

    set_capacity(6'd32);
    add_random(10);
    add_request(OP_DUMP, '0);

    wait_idle();
    if (error_count == 0) begin
      $display("bounded_array_list_top test passed");
    end else begin
      $display("bounded_array_list_top test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bal_pkg.sv
design/bal_store.sv
design/bounded_array_list_top.sv
dv/tb_top.sv
